// ===== sv/tcc_pkg.sv =====
// ---------------------------------------------------------------------------
// tcc_pkg
// constants, widths and the arctangent table shared by the compass pipeline
// ---------------------------------------------------------------------------
package tcc_pkg;

  // screen defaults
  localparam int SCREEN_WIDTH_DEF   = 128;
  localparam int SCREEN_HEIGHT_DEF  = 160;
  localparam int OFFSET_DIVISOR_DEF = 2;

  // field widths
  localparam int ANGLE_W = 16;
  localparam int TRIG_W  = 16;
  localparam int SAMP_W  = 16;
  localparam int DOT_X_W = 7;
  localparam int DOT_Y_W = 8;

  // cordic data paths
  localparam int CORDIC_STEPS = 16;
  localparam int VEC_W        = 36;
  localparam int VZ_W         = 21;
  localparam int ROT_W        = 33;
  localparam int RZ_W         = 20;

  // fixed-point constants
  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;
  localparam int PI_Q13      = 25736;
  localparam int ONE_Q14     = 16384;
  localparam int CORDIC_K30  = 652032875;

  // atan(2^-i) in Q.16
  localparam logic [15:0] ATAN_TAB [CORDIC_STEPS] = '{
    16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2
  };

  // pipeline latencies
  localparam int SQ_LAT   = 1;
  localparam int SQRT_LAT = 16;
  localparam int VEC_LAT  = CORDIC_STEPS + 2;
  localparam int ROT_LAT  = CORDIC_STEPS + 2;
  localparam int TILT_LAT = 3;
  localparam int DOT_LAT  = 3;

endpackage

// ===== sv/tilt_compensated_compass_dot.sv =====
// ---------------------------------------------------------------------------
// tilt_compensated_compass_dot
// tilt-compensated compass: pitch, roll, heading and a screen dot position
// ---------------------------------------------------------------------------
// path: input transfer to result runs through the squares, root pipeline,
//   cordic vectoring and rotation, tilt stages, heading cordic and dot stages
// throughput: one item per cycle; the whole pipeline stalls together when
//   the output register is full and not taken
// reset: clears the valid bits only; no state carries between items
module tilt_compensated_compass_dot #(
  parameter int SCREEN_WIDTH   = tcc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = tcc_pkg::SCREEN_HEIGHT_DEF,
  parameter int OFFSET_DIVISOR = tcc_pkg::OFFSET_DIVISOR_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
  input  logic [95:0] s_tdata,
  // action
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pitch_angle, roll_angle, heading_angle, dot_x, dot_y, zero pad
  output logic [63:0] m_tdata
);
  import tcc_pkg::*;

  localparam int LAT = SQ_LAT + SQRT_LAT + VEC_LAT + ROT_LAT + TILT_LAT
                     + VEC_LAT + ROT_LAT + DOT_LAT;

  logic en;
  logic vld [LAT];

  logic signed [SAMP_W-1:0] ax, ay, az;
  logic [31:0] sq_yz, sq_xz;
  logic [15:0] rt_yz, rt_xz;
  logic [31:0] acc_d;
  logic signed [SAMP_W-1:0] ax_d, ay_d;
  logic signed [ANGLE_W-1:0] pitch, roll, heading;
  logic signed [TRIG_W-1:0] cp, sp, cr, sr, ch, sh;
  logic [47:0] mag_d;
  logic signed [SAMP_W-1:0] mx_d, my_d, mz_d;
  logic action_d;
  logic [31:0] pr_d, pr_out;
  logic signed [ANGLE_W-1:0] heading_out;

  // tilt compensation registers
  logic signed [31:0] p_mxcp, p_mzsp, p_mycr, p_srsp, p_srcp;
  logic signed [15:0] q_sp, q_cp;
  logic signed [SAMP_W-1:0] t1_mx, t1_mz;
  logic signed [32:0] xh2;
  logic signed [31:0] m_mx, m_mz, m_my;
  logic signed [VEC_W-1:0] xh3, yh3;
  logic [DOT_X_W-1:0] dot_x;
  logic [DOT_Y_W-1:0] dot_y;

  // global advance: output slot empty or being taken
  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // sums of squares
  assign ax = s_tdata[15:0];
  assign ay = s_tdata[31:16];
  assign az = s_tdata[47:32];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_yz <= 32'(ay * ay) + 32'(az * az);
      sq_xz <= 32'(ax * ax) + 32'(az * az);
    end
  end

  tcc_isqrt u_sqrt_yz (.clk, .en, .radicand(sq_yz), .root(rt_yz));
  tcc_isqrt u_sqrt_xz (.clk, .en, .radicand(sq_xz), .root(rt_xz));

  tcc_delay #(.WIDTH(32), .DEPTH(SQ_LAT + SQRT_LAT)) u_acc_dly (
    .clk, .en, .din(s_tdata[31:0]), .dout(acc_d)
  );
  assign ax_d = acc_d[15:0];
  assign ay_d = acc_d[31:16];

  // pitch and roll
  tcc_vec u_vec_pitch (
    .clk, .en,
    .y_in(VEC_W'(ax_d) <<< 14),
    .x_in(VEC_W'({1'b0, rt_yz}) <<< 14),
    .angle(pitch)
  );
  tcc_vec u_vec_roll (
    .clk, .en,
    .y_in(VEC_W'(ay_d) <<< 14),
    .x_in(VEC_W'({1'b0, rt_xz}) <<< 14),
    .angle(roll)
  );

  tcc_rot u_rot_pitch (.clk, .en, .angle(pitch), .cos_out(cp), .sin_out(sp));
  tcc_rot u_rot_roll (.clk, .en, .angle(roll), .cos_out(cr), .sin_out(sr));

  tcc_delay #(.WIDTH(48), .DEPTH(SQ_LAT + SQRT_LAT + VEC_LAT + ROT_LAT)) u_mag_dly (
    .clk, .en, .din(s_tdata[95:48]), .dout(mag_d)
  );
  assign mx_d = mag_d[15:0];
  assign my_d = mag_d[31:16];
  assign mz_d = mag_d[47:32];

  // tilt stage 1: products and truncated trig products
  assign q_sp = 16'((p_srsp + ((p_srsp < 0) ? 32'sd16383 : 32'sd0)) >>> 14);
  assign q_cp = 16'((p_srcp + ((p_srcp < 0) ? 32'sd16383 : 32'sd0)) >>> 14);

  always_ff @(posedge clk) begin
    if (en) begin
      p_mxcp <= 32'(mx_d) * 32'(cp);
      p_mzsp <= 32'(mz_d) * 32'(sp);
      p_mycr <= 32'(my_d) * 32'(cr);
      p_srsp <= 32'(sr) * 32'(sp);
      p_srcp <= 32'(sr) * 32'(cp);
      t1_mx  <= mx_d;
      t1_mz  <= mz_d;
    end
  end

  // tilt stage 2: horizontal x, cross terms of y
  always_ff @(posedge clk) begin
    if (en) begin
      xh2  <= 33'(p_mxcp) + 33'(p_mzsp);
      m_mx <= 32'(t1_mx) * 32'(q_sp);
      m_mz <= 32'(t1_mz) * 32'(q_cp);
      m_my <= p_mycr;
    end
  end

  // tilt stage 3: horizontal y
  always_ff @(posedge clk) begin
    if (en) begin
      xh3 <= VEC_W'(xh2);
      yh3 <= VEC_W'(m_mx) + VEC_W'(m_my) - VEC_W'(m_mz);
    end
  end

  // heading and its cos and sin
  tcc_vec u_vec_head (.clk, .en, .y_in(yh3), .x_in(xh3), .angle(heading));
  tcc_rot u_rot_head (.clk, .en, .angle(heading), .cos_out(ch), .sin_out(sh));

  tcc_delay #(.WIDTH(1), .DEPTH(LAT - DOT_LAT)) u_act_dly (
    .clk, .en, .din(s_tuser[0]), .dout(action_d)
  );
  tcc_delay #(.WIDTH(32), .DEPTH(ROT_LAT + TILT_LAT + VEC_LAT + ROT_LAT)) u_pr_dly (
    .clk, .en, .din({roll, pitch}), .dout(pr_d)
  );

  // dot position
  tcc_dot #(.LIMIT(SCREEN_WIDTH), .DIVISOR(OFFSET_DIVISOR), .OUT_W(DOT_X_W)) u_dot_x (
    .clk, .en, .action(action_d), .tilt(pr_d[31:16]), .trig(ch), .pos(dot_x)
  );
  tcc_dot #(.LIMIT(SCREEN_HEIGHT), .DIVISOR(OFFSET_DIVISOR), .OUT_W(DOT_Y_W)) u_dot_y (
    .clk, .en, .action(action_d), .tilt(pr_d[15:0]), .trig(sh), .pos(dot_y)
  );

  tcc_delay #(.WIDTH(32), .DEPTH(DOT_LAT)) u_pr_out_dly (
    .clk, .en, .din(pr_d), .dout(pr_out)
  );
  tcc_delay #(.WIDTH(ANGLE_W), .DEPTH(ROT_LAT + DOT_LAT)) u_head_dly (
    .clk, .en, .din(heading), .dout(heading_out)
  );

  assign m_tdata = {1'b0, dot_y, dot_x, heading_out, pr_out[31:16], pr_out[15:0]};

endmodule

// ===== sv/tcc_delay.sv =====
// ---------------------------------------------------------------------------
// tcc_delay
// side-band shift line that keeps data aligned with the compute pipeline
// ---------------------------------------------------------------------------
module tcc_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  // shift on pipeline advance
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

// ===== sv/tcc_isqrt.sv =====
// ---------------------------------------------------------------------------
// tcc_isqrt
// pipelined floor square root, one result bit per stage
// ---------------------------------------------------------------------------
module tcc_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] radicand,
  output logic [15:0] root
);

  logic [31:0] v [17];
  logic [32:0] r [17];

  assign v[0] = radicand;
  assign r[0] = '0;

  for (genvar k = 0; k < 16; k++) begin : g_stage
    localparam logic [32:0] BIT = 33'd1 << (30 - 2 * k);
    logic [32:0] trial;
    logic        take;

    // trial subtract of the current bit
    assign trial = r[k] + BIT;
    assign take  = {1'b0, v[k]} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        if (take) begin
          v[k+1] <= v[k] - trial[31:0];
          r[k+1] <= (r[k] >> 1) + BIT;
        end else begin
          v[k+1] <= v[k];
          r[k+1] <= r[k] >> 1;
        end
      end
    end
  end

  assign root = r[16][15:0];

endmodule

// ===== sv/tcc_vec.sv =====
// ---------------------------------------------------------------------------
// tcc_vec
// pipelined cordic vectoring, atan2(y, x) in Q3.13 radians
// ---------------------------------------------------------------------------
module tcc_vec (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [tcc_pkg::VEC_W-1:0]  y_in,
  input  logic signed [tcc_pkg::VEC_W-1:0]  x_in,
  output logic signed [tcc_pkg::ANGLE_W-1:0] angle
);
  import tcc_pkg::*;

  logic signed [VEC_W-1:0] xs [CORDIC_STEPS+1];
  logic signed [VEC_W-1:0] ys [CORDIC_STEPS+1];
  logic signed [VZ_W-1:0]  zs [CORDIC_STEPS+1];
  logic                    skip [CORDIC_STEPS+1];
  logic signed [VZ_W-1:0]  sum;

  // fold the left half plane onto the right
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in < 0) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= (y_in >= 0) ? VZ_W'(PI_Q16) : -VZ_W'(PI_Q16);
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
      skip[0] <= (y_in == '0);
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    localparam logic signed [VZ_W-1:0] ANG = VZ_W'(ATAN_TAB[k]);

    // one micro-rotation toward the x axis
    always_ff @(posedge clk) begin
      if (en) begin
        skip[k+1] <= skip[k];
        if (skip[k]) begin
          xs[k+1] <= xs[k];
          ys[k+1] <= ys[k];
          zs[k+1] <= zs[k];
        end else if (ys[k] > 0) begin
          xs[k+1] <= xs[k] + (ys[k] >>> k);
          ys[k+1] <= ys[k] - (xs[k] >>> k);
          zs[k+1] <= zs[k] + ANG;
        end else begin
          xs[k+1] <= xs[k] - (ys[k] >>> k);
          ys[k+1] <= ys[k] + (xs[k] >>> k);
          zs[k+1] <= zs[k] - ANG;
        end
      end
    end
  end

  // round to Q3.13 and saturate at pi
  assign sum = (zs[CORDIC_STEPS] + VZ_W'(4)) >>> 3;

  always_ff @(posedge clk) begin
    if (en) begin
      if (sum > VZ_W'(PI_Q13)) begin
        angle <= ANGLE_W'(PI_Q13);
      end else if (sum < -VZ_W'(PI_Q13)) begin
        angle <= -ANGLE_W'(PI_Q13);
      end else begin
        angle <= sum[ANGLE_W-1:0];
      end
    end
  end

endmodule

// ===== sv/tcc_rot.sv =====
// ---------------------------------------------------------------------------
// tcc_rot
// pipelined cordic rotation, cos and sin of a Q3.13 angle in Q1.14
// ---------------------------------------------------------------------------
module tcc_rot (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [tcc_pkg::ANGLE_W-1:0] angle,
  output logic signed [tcc_pkg::TRIG_W-1:0]  cos_out,
  output logic signed [tcc_pkg::TRIG_W-1:0]  sin_out
);
  import tcc_pkg::*;

  localparam int RW = ROT_W - 16;

  logic signed [ROT_W-1:0] xs [CORDIC_STEPS+1];
  logic signed [ROT_W-1:0] ys [CORDIC_STEPS+1];
  logic signed [RZ_W-1:0]  zs [CORDIC_STEPS+1];
  logic                    neg [CORDIC_STEPS+1];
  logic signed [RZ_W-1:0]  z0;
  logic signed [RW-1:0]    xr, yr, xf, yf;

  assign z0 = RZ_W'(angle) <<< 3;

  // fold into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= ROT_W'(CORDIC_K30);
      ys[0] <= '0;
      if (z0 > RZ_W'(HALF_PI_Q16)) begin
        zs[0]  <= z0 - RZ_W'(PI_Q16);
        neg[0] <= 1'b1;
      end else if (z0 < -RZ_W'(HALF_PI_Q16)) begin
        zs[0]  <= z0 + RZ_W'(PI_Q16);
        neg[0] <= 1'b1;
      end else begin
        zs[0]  <= z0;
        neg[0] <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    localparam logic signed [RZ_W-1:0] ANG = RZ_W'(ATAN_TAB[k]);

    // one micro-rotation toward zero residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        neg[k+1] <= neg[k];
        if (zs[k] >= 0) begin
          xs[k+1] <= xs[k] - (ys[k] >>> k);
          ys[k+1] <= ys[k] + (xs[k] >>> k);
          zs[k+1] <= zs[k] - ANG;
        end else begin
          xs[k+1] <= xs[k] + (ys[k] >>> k);
          ys[k+1] <= ys[k] - (xs[k] >>> k);
          zs[k+1] <= zs[k] + ANG;
        end
      end
    end
  end

  // round to Q1.14, undo the fold, saturate
  assign xr = RW'((xs[CORDIC_STEPS] + ROT_W'(32768)) >>> 16);
  assign yr = RW'((ys[CORDIC_STEPS] + ROT_W'(32768)) >>> 16);
  assign xf = neg[CORDIC_STEPS] ? -xr : xr;
  assign yf = neg[CORDIC_STEPS] ? -yr : yr;

  always_ff @(posedge clk) begin
    if (en) begin
      if (xf > RW'(ONE_Q14)) cos_out <= TRIG_W'(ONE_Q14);
      else if (xf < -RW'(ONE_Q14)) cos_out <= -TRIG_W'(ONE_Q14);
      else cos_out <= xf[TRIG_W-1:0];
      if (yf > RW'(ONE_Q14)) sin_out <= TRIG_W'(ONE_Q14);
      else if (yf < -RW'(ONE_Q14)) sin_out <= -TRIG_W'(ONE_Q14);
      else sin_out <= yf[TRIG_W-1:0];
    end
  end

endmodule

// ===== sv/tcc_dot.sv =====
// ---------------------------------------------------------------------------
// tcc_dot
// one screen coordinate of the dot: scale, divide, offset and clamp
// ---------------------------------------------------------------------------
module tcc_dot #(
  parameter int LIMIT   = 128,
  parameter int DIVISOR = 2,
  parameter int OUT_W   = 7
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic                               action,
  input  logic signed [tcc_pkg::ANGLE_W-1:0] tilt,
  input  logic signed [tcc_pkg::TRIG_W-1:0]  trig,
  output logic [OUT_W-1:0]                   pos
);
  import tcc_pkg::*;

  localparam int HALF  = LIMIT / 2;
  localparam int DIV   = (DIVISOR < 1) ? 1 : DIVISOR;
  localparam int RECIP = (65536 + DIV - 1) / DIV;
  localparam int PW    = 26;
  localparam int MW    = 12;
  localparam int QW    = 29;
  localparam int SW    = 13;

  logic signed [PW-1:0] prod, prod_abs;
  logic                 act1;
  logic [MW-1:0]        mag;
  logic [QW-1:0]        scaled;
  logic                 neg2;
  logic signed [SW-1:0] quot, off, sum;

  // stage 1: scale the selected value by the half screen
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= (action ? PW'(trig) : PW'(tilt)) * PW'(HALF);
      act1 <= action;
    end
  end

  // stage 2: truncate the fraction and multiply by the divisor reciprocal
  assign prod_abs = (prod < 0) ? -prod : prod;
  assign mag      = act1 ? MW'(prod_abs >>> 14) : MW'(prod_abs >>> 13);

  always_ff @(posedge clk) begin
    if (en) begin
      scaled <= QW'(mag) * QW'(RECIP);
      neg2   <= act1 ? (prod < 0) : (prod > 0);
    end
  end

  // stage 3: offset from center and clamp to the screen
  assign quot = SW'(scaled >> 16);
  assign off  = neg2 ? -quot : quot;
  assign sum  = off + SW'(HALF + 1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (sum < 0) pos <= '0;
      else if (sum > SW'(LIMIT - 1)) pos <= OUT_W'(LIMIT - 1);
      else pos <= OUT_W'(sum);
    end
  end

endmodule

// ===== dv/tilt_compensated_compass_dot_checker.sv =====
// ---------------------------------------------------------------------------
// tilt_compensated_compass_dot_checker
// watches both stream channels, predicts pitch, roll, heading and the dot
// position for every input transfer and compares each output transfer
// ---------------------------------------------------------------------------
module tilt_compensated_compass_dot_checker #(
  parameter int SCREEN_WIDTH   = tcc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = tcc_pkg::SCREEN_HEIGHT_DEF,
  parameter int OFFSET_DIVISOR = tcc_pkg::OFFSET_DIVISOR_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcc_pkg::*;

  typedef struct packed {
    logic [15:0] pitch;
    logic [15:0] roll;
    logic [15:0] heading;
    logic [6:0]  dot_x;
    logic [7:0]  dot_y;
  } heading_t;

  heading_t expected_q[$];

  // arithmetic shift right that floors
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // cordic vectoring, Q.14 operands, Q3.13 angle out
  function automatic longint angle_of(longint y, longint x);
    longint z, base, nx, ny;
    z = 0;
    base = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? PI_Q16 : -PI_Q16;
      x = -x;
      y = -y;
    end
    if (y != 0) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (y > 0) begin
          nx = x + shr_floor(y, i); ny = y - shr_floor(x, i); z += ATAN_TAB[i];
        end else begin
          nx = x - shr_floor(y, i); ny = y + shr_floor(x, i); z -= ATAN_TAB[i];
        end
        x = nx;
        y = ny;
      end
    end
    return clip(shr_floor(base + z + 4, 3), -PI_Q13, PI_Q13);
  endfunction

  // cordic rotation, Q3.13 angle in, Q1.14 cos and sin out
  function automatic void rotate(input longint a, output longint c, output longint s);
    longint z, x, y, nx, ny;
    bit flip;
    z = a * 8;
    x = CORDIC_K30;
    y = 0;
    flip = 0;
    if (z > HALF_PI_Q16) begin
      z -= PI_Q16; flip = 1;
    end else if (z < -HALF_PI_Q16) begin
      z += PI_Q16; flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i); ny = y + shr_floor(x, i); z -= ATAN_TAB[i];
      end else begin
        nx = x + shr_floor(y, i); ny = y - shr_floor(x, i); z += ATAN_TAB[i];
      end
      x = nx;
      y = ny;
    end
    x = shr_floor(x + 32768, 16);
    y = shr_floor(y + 32768, 16);
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(x, -ONE_Q14, ONE_Q14);
    s = clip(y, -ONE_Q14, ONE_Q14);
  endfunction

  function automatic heading_t predict_heading(logic [95:0] d, logic act);
    longint ax, ay, az, mx, my, mz, dv, hw, hh;
    longint pitch, roll, hdg, cp, sp, cr, sr, ch, sh, xh, yh, ox, oy;
    heading_t r;
    ax = longint'(signed'(d[15:0]));
    ay = longint'(signed'(d[31:16]));
    az = longint'(signed'(d[47:32]));
    mx = longint'(signed'(d[63:48]));
    my = longint'(signed'(d[79:64]));
    mz = longint'(signed'(d[95:80]));
    dv = OFFSET_DIVISOR < 1 ? 1 : OFFSET_DIVISOR;
    hw = SCREEN_WIDTH / 2;
    hh = SCREEN_HEIGHT / 2;
    pitch = angle_of(ax * 16384, root_floor(ay * ay + az * az) * 16384);
    roll  = angle_of(ay * 16384, root_floor(ax * ax + az * az) * 16384);
    rotate(pitch, cp, sp);
    rotate(roll, cr, sr);
    xh = mx * cp + mz * sp;
    yh = mx * ((sr * sp) / 16384) + my * cr - mz * ((sr * cp) / 16384);
    hdg = angle_of(yh, xh);
    if (!act) begin
      ox = -(((roll * hw) / 8192) / dv);
      oy = -(((pitch * hh) / 8192) / dv);
    end else begin
      rotate(hdg, ch, sh);
      ox = ((ch * hw) / 16384) / dv;
      oy = ((sh * hh) / 16384) / dv;
    end
    r.pitch   = pitch[15:0];
    r.roll    = roll[15:0];
    r.heading = hdg[15:0];
    r.dot_x   = 7'(clip(hw + ox + 1, 0, SCREEN_WIDTH - 1));
    r.dot_y   = 8'(clip(hh + oy + 1, 0, SCREEN_HEIGHT - 1));
    return r;
  endfunction

  // predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    heading_t want, got;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_q.push_back(predict_heading(s_tdata, s_tuser[0]));
      if (m_tvalid && m_tready) begin
        got.pitch   = m_tdata[15:0];
        got.roll    = m_tdata[31:16];
        got.heading = m_tdata[47:32];
        got.dot_x   = m_tdata[54:48];
        got.dot_y   = m_tdata[62:55];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.pitch !== got.pitch)
            $display("%0t: pitch expected %0d actual %0d", $time,
                     signed'(want.pitch), signed'(got.pitch));
          if (want.roll !== got.roll)
            $display("%0t: roll expected %0d actual %0d", $time,
                     signed'(want.roll), signed'(got.roll));
          if (want.heading !== got.heading)
            $display("%0t: heading expected %0d actual %0d", $time,
                     signed'(want.heading), signed'(got.heading));
          if (want.dot_x !== got.dot_x)
            $display("%0t: dot_x expected %0d actual %0d", $time, want.dot_x, got.dot_x);
          if (want.dot_y !== got.dot_y)
            $display("%0t: dot_y expected %0d actual %0d", $time, want.dot_y, got.dot_y);
          if (want !== got) fail_count <= fail_count + 1;
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ===== dv/tilt_compensated_compass_dot_test.sv =====
// ---------------------------------------------------------------------------
// tilt_compensated_compass_dot_test
// drives sensor samples with random gaps and output stalls, including a long
// output hold-off and a drain pause; the checker does the comparison
// ---------------------------------------------------------------------------
module tilt_compensated_compass_dot_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 95;
  localparam int MAX_CYCLE = 400000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
  logic [0:0]  s_tuser;   // action
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // pitch, roll, heading, dot_x, dot_y, zero pad
  int          fail_count;
  int          pending;
  int          send_idle;   // percent of cycles the sender holds back
  int          recv_stall;  // percent of cycles the receiver stalls
  int          hold_off;    // cycles of forced receiver stall
  int          cycle;

  tilt_compensated_compass_dot uut (.*);
  tilt_compensated_compass_dot_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle counter and timeout
  initial begin
    cycle = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle > MAX_CYCLE) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver side: random stall plus long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // one sample: offer until taken, with random idle before it
  task automatic send_sample(logic act, logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [15:0] mx, logic [15:0] my, logic [15:0] mz);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= act;
    s_tdata  <= {mz, my, mx, az, ay, ax};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(signed'($urandom_range(8192)) - 4096);
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int n);
    repeat (n) send_sample(1'($urandom_range(1)), rand_field(), rand_field(), rand_field(),
                           rand_field(), rand_field(), rand_field());
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_off = 0;
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: zero vectors, extremes, both actions, off-screen dots
    for (int a = 0; a < 2; a++) begin
      send_sample(1'(a), 0, 0, 0, 0, 0, 0);
      send_sample(1'(a), 16'h7fff, 0, 0, 16'h7fff, 0, 0);
      send_sample(1'(a), 16'h8000, 0, 0, 16'h8000, 16'h8000, 16'h8000);
      send_sample(1'(a), 0, 16'h7fff, 0, 0, 16'h7fff, 0);
      send_sample(1'(a), 0, 16'h8000, 16'h1000, 16'hf000, 0, 16'h7fff);
      send_sample(1'(a), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_sample(1'(a), 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_sample(1'(a), 16'h0400, 16'hfc00, 16'h1000, 16'hfe00, 16'h0200, 16'h0800);
      send_sample(1'(a), 16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001);
      send_sample(1'(a), 0, 0, 16'h8000, 16'h1000, 16'hf000, 0);
    end

    // random phases with different idle mixes
    send_random(120);
    send_idle = 47;
    send_random(100);
    send_idle = 0;
    recv_stall = 47;
    send_random(100);
    send_idle = 26;
    recv_stall = 26;
    send_random(80);

    // long output hold-off while the sender keeps offering
    send_idle = 0;
    recv_stall = 0;
    s_tvalid <= 0;
    @(posedge clk);
    hold_off <= 300;
    send_random(120);

    // pause until everything has drained, then a final burst
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    send_random(20);
    s_tvalid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tcc_pkg.sv
sv/tcc_delay.sv
sv/tcc_isqrt.sv
sv/tcc_vec.sv
sv/tcc_rot.sv
sv/tcc_dot.sv
sv/tilt_compensated_compass_dot.sv
dv/tilt_compensated_compass_dot_checker.sv
dv/tilt_compensated_compass_dot_test.sv
